@@ hw/rtl/crp_pkg.sv @@
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the CRP cluster sampler
// Field widths, parameter defaults and the request kind codes.
// ----------------------------------------------------------------------------
package crp_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned MAX_CLUSTERS_DEF = 1024;
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned TOTAL_BITS_DEF   = 20;

  // Fixed field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned RAND_W   = 32;
  localparam int unsigned DRAW_W   = 11;

  // Alpha resets to 1.0 in Q8.8.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;

  // Alpha has 8 fractional bits; the random value has 32.
  localparam int unsigned ALPHA_FRAC_W = 8;
  localparam int unsigned PROD_SHIFT   = RAND_W + ALPHA_FRAC_W;

  // Request kinds. The fourth code is unused and ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

endpackage

@@ hw/rtl/crp_if.sv @@
// ----------------------------------------------------------------------------
// crp_if: channel interfaces for the CRP cluster sampler
// Input request, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------

// Input request channel.
interface crp_in_if
  import crp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned TOTAL_BITS = TOTAL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [TOTAL_BITS-1:0] total_count;
  logic [RAND_W-1:0]     random_value;
  logic [COUNT_BITS-1:0] cluster_count;

  modport source (output valid, kind, total_count, random_value, cluster_count,
                  input ready);
  modport sink   (input valid, kind, total_count, random_value, cluster_count,
                  output ready);
endinterface

// Result channel.
interface crp_out_if
  import crp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] draw_index;
  logic              overflow;

  modport source (output valid, draw_index, overflow, input ready);
  modport sink   (input valid, draw_index, overflow, output ready);
endinterface

// Configuration write channel for the alpha register.
interface crp_cfg_if
  import crp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/crp_cluster_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// crp_cluster_sampler_unit: Chinese restaurant process cluster draw
// A start request loads the threshold u * (total + alpha), count requests
// accumulate a saturating running sum, and a finish request returns the
// first cluster whose running sum exceeds the threshold, or else a new cluster.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Payload
//   in_chan   sink       valid / ready    kind, total_count, random_value,
//                                         cluster_count
//   out_chan  source     valid / ready    draw_index, overflow
//   cfg_chan  sink       valid / ready    data (alpha, Q8.8)
//
// Every request is captured in an input register and acted on from it, so one
// request enters per cycle unless in_chan stalls. A finish result goes from
// there to the result register and shows on out_chan. The 32 x (TOTAL_BITS+9)
// threshold multiply and the running-sum add and compare are combinational.
// in_chan stalls only when a finish request waits on a held result.
// rst_n is synchronous; it clears the draw state and sets alpha to 1.0, and
// in_chan and cfg_chan hold ready low while it is asserted.
//
module crp_cluster_sampler_unit
  import crp_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF,
  parameter int unsigned TOTAL_BITS   = TOTAL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  crp_in_if.sink     in_chan,
  crp_out_if.source  out_chan,
  crp_cfg_if.sink    cfg_chan
);

  // Derived widths.
  localparam int unsigned IDX_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SUM_W  = TOTAL_BITS + 1;
  localparam int unsigned PART_W = TOTAL_BITS + ALPHA_FRAC_W + 1;
  localparam int unsigned PROD_W = RAND_W + PART_W;
  localparam int unsigned ACC_W  = ((SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS) + 1;

  // Configuration register.
  logic [ALPHA_W-1:0] alpha_r;

  // Input register.
  logic                  stg_vld_r;
  kind_t                 stg_kind_r;
  logic [TOTAL_BITS-1:0] stg_total_r;
  logic [RAND_W-1:0]     stg_rand_r;
  logic [COUNT_BITS-1:0] stg_count_r;

  // Draw state.
  logic [SUM_W-1:0] threshold_r,   threshold_nxt;
  logic [SUM_W-1:0] running_sum_r, running_sum_nxt;
  logic [IDX_W-1:0] elem_idx_r,    elem_idx_nxt;
  logic             found_r,       found_nxt;
  logic [IDX_W-1:0] chosen_idx_r,  chosen_idx_nxt;
  logic             overflowed_r,  overflowed_nxt;

  // Result register.
  logic              out_vld_r,  out_vld_nxt;
  logic [DRAW_W-1:0] out_draw_r, out_draw_nxt;
  logic              out_ovf_r,  out_ovf_nxt;

  logic stg_advance;
  logic in_take;

  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  acc;
  logic [SUM_W-1:0]  sum_sat;
  logic [IDX_W-1:0]  draw_sel;

  // The staged request moves on unless it is a finish blocked by a held result.
  assign stg_advance = !(stg_vld_r && (stg_kind_r == KIND_FINISH) &&
                         out_vld_r && !out_chan.ready);
  assign in_chan.ready = rst_n && stg_advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign cfg_chan.ready = rst_n;

  // Alpha register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      alpha_r <= cfg_chan.data;
    end
  end

  // Input register: valid flag is control, payload loads on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (stg_advance) begin
      stg_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_kind_r  <= kind_t'(in_chan.kind);
      stg_total_r <= in_chan.total_count;
      stg_rand_r  <= in_chan.random_value;
      stg_count_r <= in_chan.cluster_count;
    end
  end

  // Threshold: floor(u * (total*256 + alpha) / 2^40), exact.
  assign part    = (PART_W'(stg_total_r) << ALPHA_FRAC_W) + PART_W'(alpha_r);
  assign product = PROD_W'(stg_rand_r) * PROD_W'(part);

  // Saturating running sum.
  assign acc     = ACC_W'(running_sum_r) + ACC_W'(stg_count_r);
  assign sum_sat = (|acc[ACC_W-1:SUM_W]) ? {SUM_W{1'b1}} : acc[SUM_W-1:0];

  assign draw_sel = found_r ? chosen_idx_r : elem_idx_r;

  // Next draw state and result.
  always_comb begin
    threshold_nxt   = threshold_r;
    running_sum_nxt = running_sum_r;
    elem_idx_nxt    = elem_idx_r;
    found_nxt       = found_r;
    chosen_idx_nxt  = chosen_idx_r;
    overflowed_nxt  = overflowed_r;
    out_vld_nxt     = out_vld_r && !out_chan.ready;
    out_draw_nxt    = out_draw_r;
    out_ovf_nxt     = out_ovf_r;

    if (stg_vld_r && stg_advance) begin
      unique case (stg_kind_r)
        KIND_START: begin
          threshold_nxt   = product[PROD_W-1:PROD_SHIFT];
          running_sum_nxt = '0;
          elem_idx_nxt    = '0;
          found_nxt       = 1'b0;
          chosen_idx_nxt  = '0;
          overflowed_nxt  = 1'b0;
        end
        KIND_COUNT: begin
          if (elem_idx_r >= IDX_W'(MAX_CLUSTERS)) begin
            overflowed_nxt = 1'b1;
          end else begin
            running_sum_nxt = sum_sat;
            elem_idx_nxt    = elem_idx_r + IDX_W'(1);
            if (!found_r && (sum_sat > threshold_r)) begin
              found_nxt      = 1'b1;
              chosen_idx_nxt = elem_idx_r;
            end
          end
        end
        KIND_FINISH: begin
          out_vld_nxt  = 1'b1;
          out_draw_nxt = DRAW_W'(draw_sel);
          out_ovf_nxt  = overflowed_r;
        end
        default: begin
          // The unused code leaves everything as it is.
        end
      endcase
    end
  end

  // Draw state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= '0;
      running_sum_r <= '0;
      elem_idx_r    <= '0;
      found_r       <= 1'b0;
      chosen_idx_r  <= '0;
      overflowed_r  <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      threshold_r   <= threshold_nxt;
      running_sum_r <= running_sum_nxt;
      elem_idx_r    <= elem_idx_nxt;
      found_r       <= found_nxt;
      chosen_idx_r  <= chosen_idx_nxt;
      overflowed_r  <= overflowed_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_draw_r <= out_draw_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.draw_index = out_draw_r;
  assign out_chan.overflow   = out_ovf_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the CRP cluster sampler
// Sends start, count and finish requests over valid/ready channels with
// random idling, back-pressure and several alpha settings. A local predictor
// tracks the threshold, running sum and draw, and every result is checked.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crp_pkg::*;

  localparam int unsigned MAX_CL = MAX_CLUSTERS_DEF;
  localparam int unsigned CNT_W  = COUNT_BITS_DEF;
  localparam int unsigned TOT_W  = TOTAL_BITS_DEF;
  localparam int unsigned SUM_W  = TOT_W + 1;
  localparam int unsigned THR_W  = 61;
  localparam logic [SUM_W-1:0]  SUM_CEIL    = '1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned IDLE_PCT      = 35;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned NUM_PHASES    = 5;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOT_W-1:0]  total;
    logic [RAND_W-1:0] rnd;
    logic [CNT_W-1:0]  count;
  } request_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw;
    logic              ovf;
  } draw_result_t;

  typedef struct {
    request_t     req;
    int unsigned  reps;
    bit           typed;
    draw_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  crp_in_if #(.COUNT_BITS(CNT_W), .TOTAL_BITS(TOT_W)) in_bus ();
  crp_out_if out_bus ();
  crp_cfg_if cfg_bus ();

  crp_cluster_sampler_unit #(
    .MAX_CLUSTERS(MAX_CL),
    .COUNT_BITS  (CNT_W),
    .TOTAL_BITS  (TOT_W)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .cfg_chan(cfg_bus)
  );

  // Predicted sampler state, updated at each accepted request.
  logic [ALPHA_W-1:0] alpha_q = ALPHA_RESET;
  logic [THR_W-1:0]   thr_q    = '0;
  logic [SUM_W-1:0]   sum_q    = '0;
  logic [DRAW_W-1:0]  seen_q   = '0;
  logic [DRAW_W-1:0]  chosen_q = '0;
  logic               found_q  = 1'b0;
  logic               ovf_q    = 1'b0;

  draw_result_t expected_draws[$];
  stim_row_t    stim_table[$];

  int unsigned fail_count   = 0;
  int unsigned sent_items   = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_enable  = 1'b1;
  bit          hold_request = 1'b0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // Advance the predicted state by one request; returns 1 when a draw is due.
  function automatic bit predict_draw(input request_t r, output draw_result_t res);
    logic [63:0]      prod;
    logic [SUM_W:0]   wide_sum;
    res = '0;
    predict_draw = 1'b0;
    case (r.kind)
      KIND_START: begin
        prod = 64'(r.rnd) * ((64'(r.total) << ALPHA_FRAC_W) + 64'(alpha_q));
        thr_q    = THR_W'(prod >> PROD_SHIFT);
        sum_q    = '0;
        seen_q   = '0;
        found_q  = 1'b0;
        chosen_q = '0;
        ovf_q    = 1'b0;
      end
      KIND_COUNT: begin
        if (seen_q >= DRAW_W'(MAX_CL)) begin
          ovf_q = 1'b1;
        end else begin
          wide_sum = {1'b0, sum_q} + (SUM_W+1)'(r.count);
          sum_q = (wide_sum > {1'b0, SUM_CEIL}) ? SUM_CEIL : wide_sum[SUM_W-1:0];
          if (!found_q && (THR_W'(sum_q) > thr_q)) begin
            found_q  = 1'b1;
            chosen_q = seen_q;
          end
          seen_q = seen_q + DRAW_W'(1);
        end
      end
      KIND_FINISH: begin
        res.draw = found_q ? chosen_q : seen_q;
        res.ovf  = ovf_q;
        predict_draw = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_row(input logic [KIND_W-1:0] k, input logic [TOT_W-1:0] t,
                                  input logic [RAND_W-1:0] u, input logic [CNT_W-1:0] c,
                                  input int unsigned n, input bit typed,
                                  input logic [DRAW_W-1:0] d, input logic o);
    stim_row_t row;
    row.req   = '{kind: k, total: t, rnd: u, count: c};
    row.reps  = n;
    row.typed = typed;
    row.want  = '{draw: d, ovf: o};
    stim_table.insert(stim_table.size(), row);
  endfunction

  // Offer one request, with random idle cycles first, and wait for acceptance.
  task automatic send_request(input request_t r, input bit typed, input draw_result_t want);
    draw_result_t res;
    @(negedge clk);
    while (idle_enable && ($urandom_range(99) < IDLE_PCT)) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= r.kind;
    in_bus.total_count   <= r.total;
    in_bus.random_value  <= r.rnd;
    in_bus.cluster_count <= r.count;
    do @(posedge clk); while (!in_bus.ready);
    if (predict_draw(r, res)) begin
      expected_draws.insert(expected_draws.size(), typed ? want : res);
    end
    if (r.kind != KIND_UNUSED) begin
      sent_items++;
    end
  endtask

  // Stop offering, wait for every pending draw, then let the pipeline settle.
  task automatic settle_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [ALPHA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    alpha_q = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One well-formed draw: start, a list of counts, finish, sometimes finish again.
  task automatic run_sequence(input int unsigned n_counts);
    logic [CNT_W-1:0]    counts[$];
    logic [TOT_W+11:0]   sum;
    logic [CNT_W-1:0]    c;
    request_t            r;
    draw_result_t        none;
    none = '0;
    sum  = '0;
    for (int unsigned i = 0; i < n_counts; i++) begin
      case ($urandom_range(7))
        0:       c = '0;
        1:       c = '1;
        2, 3:    c = CNT_W'($urandom);
        default: c = CNT_W'($urandom_range(300));
      endcase
      counts.insert(counts.size(), c);
      sum += (TOT_W+12)'(c);
    end
    r.kind  = KIND_START;
    r.total = ($urandom_range(9) == 0) ? TOT_W'($urandom) : sum[TOT_W-1:0];
    r.rnd   = $urandom;
    r.count = CNT_W'($urandom);
    send_request(r, 1'b0, none);
    foreach (counts[i]) begin
      r.kind  = KIND_COUNT;
      r.total = TOT_W'($urandom);
      r.rnd   = $urandom;
      r.count = counts[i];
      send_request(r, 1'b0, none);
    end
    r.kind = KIND_FINISH;
    send_request(r, 1'b0, none);
    if ($urandom_range(4) == 0) begin
      send_request(r, 1'b0, none);
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_bus.ready <= !(idle_enable && ($urandom_range(99) < IDLE_PCT));
      end
    end
  end

  // Compare each accepted result with the oldest pending draw.
  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_draws.size() == 0) begin
        note_failure($sformatf("unexpected result draw_index=%0d overflow=%0b",
                               out_bus.draw_index, out_bus.overflow));
      end else begin
        want = expected_draws.pop_front();
        if (out_bus.draw_index !== want.draw) begin
          note_failure($sformatf("draw_index expected %0d got %0d",
                                 want.draw, out_bus.draw_index));
        end
        if (out_bus.overflow !== want.ovf) begin
          note_failure($sformatf("overflow expected %0b got %0b",
                                 want.ovf, out_bus.overflow));
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves a request.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases per alpha setting.
  initial begin : main_flow
    request_t           r;
    draw_result_t       none;
    logic [ALPHA_W-1:0] phase_alpha[NUM_PHASES];
    int unsigned        phase_end;
    bit                 paused;

    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = KIND_START;
    in_bus.total_count   = '0;
    in_bus.random_value  = '0;
    in_bus.cluster_count = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    none                 = '0;
    paused               = 1'b0;

    // Finish straight after reset draws cluster zero.
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd0, 1'b0);
    // Counts without a start work against the zero threshold.
    add_row(KIND_COUNT, '0, '0, 16'h0000, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'hFFFF, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd1, 1'b0);
    // The unused kind is ignored, whatever its fields.
    add_row(KIND_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b0, '0, 1'b0);
    // Zero threshold and only empty clusters: new cluster, then repeated finish.
    add_row(KIND_START, 20'h00000, 32'h0000_0000, '0, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'h0000, 3, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd3, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'h0001, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd3, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd3, 1'b0);
    // Largest threshold, crossed just after sixteen full counts.
    add_row(KIND_START, 20'hFFFFF, 32'hFFFF_FFFF, '0, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'hFFFF, 16, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'hFFFF, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'h0000, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b0, '0, 1'b0);
    // A full list of empty clusters: the draw is the cluster bound.
    add_row(KIND_START, 20'hFFFFF, 32'hFFFF_FFFF, '0, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'h0000, MAX_CL, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd1024, 1'b0);
    // One count past the bound sets the overflow flag and leaves the draw.
    add_row(KIND_COUNT, '0, '0, 16'hFFFF, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd1024, 1'b1);
    // Full counts against a zero threshold drive the running sum into saturation.
    add_row(KIND_START, 20'h00000, 32'h0000_0000, '0, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'hFFFF, 40, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b1, 11'd0, 1'b0);
    // Mixed bit patterns.
    add_row(KIND_START, 20'h5A5A5, 32'hA5A5_A5A5, 16'h5555, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, 20'hA5A5A, 32'h5A5A_5A5A, 16'h5555, 1, 1'b0, '0, 1'b0);
    add_row(KIND_COUNT, '0, '0, 16'hAAAA, 1, 1'b0, '0, 1'b0);
    add_row(KIND_FINISH, '0, '0, '0, 1, 1'b0, '0, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with alpha at its reset value.
    foreach (stim_table[i]) begin
      repeat (stim_table[i].reps) begin
        send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
      end
    end
    settle_input();

    // Random phases, each with its own alpha; the third runs twice as long
    // with no idling on either side.
    phase_alpha = '{16'd0, 16'hFFFF, ALPHA_W'($urandom), 16'd1, ALPHA_W'($urandom)};
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_alpha(phase_alpha[p]);
      idle_enable = (p != 2);
      if (p == 1) begin
        hold_request = 1'b1;
      end
      phase_end = sent_items + ((p == 2) ? 2 * PHASE_ITEMS : PHASE_ITEMS);
      while (sent_items < phase_end) begin
        if ((p == 3) && !paused && (sent_items + PHASE_ITEMS / 2 >= phase_end)) begin
          settle_input();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          run_sequence($urandom_range(16));
        end else begin
          r.kind  = KIND_W'($urandom_range(3));
          r.total = TOT_W'($urandom);
          r.rnd   = $urandom;
          r.count = CNT_W'($urandom);
          send_request(r, 1'b0, none);
        end
      end
      settle_input();
    end

    repeat (8) @(posedge clk);
    if ((fail_count == 0) && (expected_draws.size() == 0)) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
